>>> rtl/angle_deficit_curvature_macros.svh
// Assertion helpers for the angle deficit curvature block.
`ifndef ANGLE_DEFICIT_CURVATURE_MACROS_SVH
`define ANGLE_DEFICIT_CURVATURE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising edge outside reset.
`define ADC_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("angle_deficit_curvature: implication check failed");
// Next-cycle implication, checked on the rising edge outside reset.
`define ADC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("angle_deficit_curvature: next-cycle check failed");
`else
`define ADC_ASSERT_IMPLY(name, clk, rstn, ante, cons)
`define ADC_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/adc_pkg.sv
`timescale 1ns / 1ps
package adc_pkg;

    // Default angle precision in fraction bits.
    localparam int ANGLE_FRAC_BITS_DEF = 29;
    // Offsets are normalised to this many magnitude bits.
    localparam int NORM_BITS = 15;
    // Angles in Q32 radians.
    localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
    localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;
    // Saturation limit of the angle sum.
    localparam logic [39:0] ANGLE_SUM_MAX = 40'h7F_FFFF_FFFF;

    typedef logic signed [32:0] offset_t;
    typedef logic signed [16:0] norm_t;

    // Magnitude of an offset component.
    function automatic logic [32:0] mag33(input offset_t v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // Number of significant bits of a magnitude.
    function automatic logic [5:0] bit_len(input logic [32:0] m);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 33; i++) begin
            if (m[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

    // Scale one component so that the largest magnitude has NORM_BITS bits.
    function automatic norm_t scale_comp(input offset_t v, input logic [5:0] len);
        logic signed [32:0] t;
        if (len == 6'd0) begin
            t = '0;
        end else if (len > 6'(NORM_BITS)) begin
            t = v >>> (len - 6'(NORM_BITS));
        end else begin
            t = v <<< (6'(NORM_BITS) - len);
        end
        return t[16:0];
    endfunction

    // CORDIC step angles, floor(atan(2^-i) * 2^32).
    function automatic logic [31:0] atan_step(input logic [4:0] i);
        logic [32:0] one_sh;
        one_sh = 33'd1 << (6'd32 - 6'(i));
        case (i)
            5'd0:    return 32'd3373259426;
            5'd1:    return 32'd1991351317;
            5'd2:    return 32'd1052175346;
            5'd3:    return 32'd534100634;
            5'd4:    return 32'd268086747;
            5'd5:    return 32'd134174062;
            5'd6:    return 32'd67103403;
            5'd7:    return 32'd33553749;
            5'd8:    return 32'd16777130;
            5'd9:    return 32'd8388597;
            5'd10:   return 32'd4194302;
            default: return 32'(one_sh - 33'd1);
        endcase
    endfunction

endpackage

>>> rtl/angle_deficit_curvature.sv
`timescale 1ns / 1ps
`include "angle_deficit_curvature_macros.svh"
// Channel  | direction | tdata (low bit first)                         | tlast    | tuser
// s_       | in        | nbr x, nbr y, nbr z, ctr x, ctr y, ctr z, area | ring_end | -
// m_       | out       | curvature                                     | -        | area_error
//
// One angle passes through scaling, the multiplies, the square root, the CORDIC and the sum.
// The first neighbour of a ring only stores its offset and an inner neighbour yields one angle;
// the last yields that angle and the closing one (only the closing one if first), then runs the
// bit-serial divider unless the area is zero. Root, CORDIC and divide loops are bit-per-cycle;
// s_tready stays low. aresetn is synchronous and clears the sequencer, ring state and angle sum.
// A result waits in its register while m_tready is low; no request is taken until it leaves.
module angle_deficit_curvature #(
    parameter int ANGLE_FRAC_BITS = adc_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // nbr x, nbr y, nbr z, ctr x, ctr y, ctr z, vertex area
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // curvature
    output logic [0:0]   m_tuser    // area_error
);
    import adc_pkg::*;

    localparam int          SH         = 32 - ANGLE_FRAC_BITS;
    localparam logic [63:0] RND        = (64'd1 << SH) >> 1;
    localparam logic [63:0] TWO_PI_ANG = (TWO_PI_Q32 + RND) >> SH;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCALE  = 8'b0000_0010,
        ST_MUL    = 8'b0000_0100,
        ST_SQRT   = 8'b0000_1000,
        ST_CORDIC = 8'b0001_0000,
        ST_ACCUM  = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t             state_reg;
    offset_t            first_reg [3];
    offset_t            prev_reg  [3];
    offset_t            a_reg     [3];
    offset_t            b_reg     [3];
    norm_t              p_reg     [3];
    norm_t              q_reg     [3];
    logic signed [33:0] c_reg     [3];
    logic signed [65:0] prod_reg;
    logic signed [34:0] dot_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        rad_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic signed [39:0] x_reg;
    logic signed [39:0] y_reg;
    logic signed [36:0] z_reg;
    logic [39:0]        sum_reg;
    logic               started_reg;
    logic               end_reg;
    logic               close_reg;
    logic [31:0]        area_reg;
    logic [5:0]         cnt_reg;
    logic [63:0]        mag_reg;
    logic [63:0]        quo_reg;
    logic [32:0]        rem_reg;
    logic               neg_reg;
    logic [31:0]        curv_reg;
    logic               err_reg;

    offset_t            d_in [3];
    logic [5:0]         len_a;
    logic [5:0]         len_b;
    logic signed [33:0] cabs [3];
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic [63:0]        sq_fin;
    logic [63:0]        root_try;
    logic               root_ge;
    logic [63:0]        root_nx;
    logic [63:0]        rad_nx;
    logic signed [39:0] y_init;
    logic signed [39:0] dx;
    logic signed [39:0] dy;
    logic [4:0]         cidx;
    logic [63:0]        ang;
    logic [63:0]        sum_add;
    logic [39:0]        sum_new;
    logic signed [41:0] num;
    logic [40:0]        num_abs;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic [63:0]        q_fin;
    logic [31:0]        q_sat;
    logic               accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = curv_reg;
    assign m_tuser  = err_reg;

    // Offsets of the incoming neighbour from the centre, 33 bits each.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_in[k] = {s_tdata[32*k+31], s_tdata[32*k +: 32]}
                    - {s_tdata[32*(k+3)+31], s_tdata[32*(k+3) +: 32]};
        end
    end

    // Normalising lengths of the two vectors.
    assign len_a = bit_len(mag33(a_reg[0]) | mag33(a_reg[1]) | mag33(a_reg[2]));
    assign len_b = bit_len(mag33(b_reg[0]) | mag33(b_reg[1]) | mag33(b_reg[2]));

    // Operand selection for the shared multiplier.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cabs[k] = c_reg[k][33] ? -c_reg[k] : c_reg[k];
        end
        op_a = '0;
        op_b = '0;
        case (cnt_reg)
            6'd0:  begin op_a = 33'(p_reg[1]); op_b = 33'(q_reg[2]); end
            6'd1:  begin op_a = 33'(p_reg[2]); op_b = 33'(q_reg[1]); end
            6'd2:  begin op_a = 33'(p_reg[2]); op_b = 33'(q_reg[0]); end
            6'd3:  begin op_a = 33'(p_reg[0]); op_b = 33'(q_reg[2]); end
            6'd4:  begin op_a = 33'(p_reg[0]); op_b = 33'(q_reg[1]); end
            6'd5:  begin op_a = 33'(p_reg[1]); op_b = 33'(q_reg[0]); end
            6'd6:  begin op_a = 33'(p_reg[0]); op_b = 33'(q_reg[0]); end
            6'd7:  begin op_a = 33'(p_reg[1]); op_b = 33'(q_reg[1]); end
            6'd8:  begin op_a = 33'(p_reg[2]); op_b = 33'(q_reg[2]); end
            6'd9:  begin op_a = 33'(cabs[0]); op_b = 33'(cabs[0]); end
            6'd10: begin op_a = 33'(cabs[1]); op_b = 33'(cabs[1]); end
            6'd11: begin op_a = 33'(cabs[2]); op_b = 33'(cabs[2]); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // One step of the integer square root.
    always_comb begin
        sq_fin   = sq_reg + prod_reg[63:0];
        root_try = root_reg + bit_reg;
        root_ge  = (rad_reg >= root_try);
        rad_nx   = root_ge ? (rad_reg - root_try) : rad_reg;
        root_nx  = root_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
        y_init   = 40'(root_nx);
    end

    // One CORDIC vectoring step.
    assign cidx = cnt_reg[4:0];
    assign dx   = y_reg >>> cidx;
    assign dy   = x_reg >>> cidx;

    // Angle rounding, saturating sum and the numerator of the quotient.
    always_comb begin
        ang     = (z_reg[36] ? 64'd0 : 64'(z_reg)) + RND;
        ang     = ang >> SH;
        sum_add = 64'(sum_reg) + ang;
        sum_new = (sum_add > 64'(ANGLE_SUM_MAX)) ? ANGLE_SUM_MAX : sum_add[39:0];
        num     = 42'(TWO_PI_ANG[41:0]) - 42'(sum_new);
        num_abs = num[41] ? 41'(-num) : num[40:0];
    end

    // One step of the restoring divider, then saturation to Q16.16.
    always_comb begin
        rem_sh = {rem_reg[31:0], mag_reg[63]};
        div_ge = (rem_sh >= {1'b0, area_reg});
        q_fin  = {quo_reg[62:0], div_ge};
        if (!neg_reg) begin
            q_sat = (q_fin > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_fin[31:0];
        end else begin
            q_sat = (q_fin > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q_fin[31:0]);
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            for (int k = 0; k < 3; k++) begin
                first_reg[k] <= '0;
                prev_reg[k]  <= '0;
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        end_reg  <= s_tlast;
                        area_reg <= s_tdata[223:192];
                        if (!started_reg) begin
                            for (int k = 0; k < 3; k++) begin
                                first_reg[k] <= d_in[k];
                                prev_reg[k]  <= d_in[k];
                                a_reg[k]     <= d_in[k];
                                b_reg[k]     <= d_in[k];
                            end
                            sum_reg     <= '0;
                            started_reg <= 1'b1;
                            close_reg   <= 1'b1;
                            state_reg   <= s_tlast ? ST_SCALE : ST_IDLE;
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                a_reg[k]    <= prev_reg[k];
                                b_reg[k]    <= d_in[k];
                                prev_reg[k] <= d_in[k];
                            end
                            close_reg <= 1'b0;
                            state_reg <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE: begin
                    for (int k = 0; k < 3; k++) begin
                        p_reg[k] <= scale_comp(a_reg[k], len_a);
                        q_reg[k] <= scale_comp(b_reg[k], len_b);
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // Products are issued one per cycle into prod_reg and folded in from there.
                    prod_reg <= 66'(op_a) * 66'(op_b);
                    case (cnt_reg)
                        6'd1:  c_reg[0] <= 34'(prod_reg);
                        6'd2:  c_reg[0] <= c_reg[0] - 34'(prod_reg);
                        6'd3:  c_reg[1] <= 34'(prod_reg);
                        6'd4:  c_reg[1] <= c_reg[1] - 34'(prod_reg);
                        6'd5:  c_reg[2] <= 34'(prod_reg);
                        6'd6:  c_reg[2] <= c_reg[2] - 34'(prod_reg);
                        6'd7:  dot_reg  <= 35'(prod_reg);
                        6'd8:  dot_reg  <= dot_reg + 35'(prod_reg);
                        6'd9:  dot_reg  <= dot_reg + 35'(prod_reg);
                        6'd10: sq_reg   <= prod_reg[63:0];
                        6'd11: sq_reg   <= sq_reg + prod_reg[63:0];
                        default: begin
                        end
                    endcase
                    if (cnt_reg == 6'd12) begin
                        rad_reg   <= sq_fin;
                        root_reg  <= '0;
                        bit_reg   <= 64'd1 << 62;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_SQRT: begin
                    rad_reg  <= rad_nx;
                    root_reg <= root_nx;
                    bit_reg  <= bit_reg >> 2;
                    if (cnt_reg == 6'd31) begin
                        // Start the CORDIC, turning a left half-plane vector by -pi/2.
                        if (dot_reg[34]) begin
                            x_reg <= y_init;
                            y_reg <= -40'(dot_reg);
                            z_reg <= 37'(HALF_PI_Q32);
                        end else begin
                            x_reg <= 40'(dot_reg);
                            y_reg <= y_init;
                            z_reg <= '0;
                        end
                        cnt_reg   <= '0;
                        state_reg <= ST_CORDIC;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_CORDIC: begin
                    if (y_reg != 40'sd0) begin
                        if (!y_reg[39]) begin
                            x_reg <= x_reg + dx;
                            y_reg <= y_reg - dy;
                            z_reg <= z_reg + 37'(atan_step(cidx));
                        end else begin
                            x_reg <= x_reg - dx;
                            y_reg <= y_reg + dy;
                            z_reg <= z_reg - 37'(atan_step(cidx));
                        end
                    end
                    if (cnt_reg == 6'd31) begin
                        state_reg <= ST_ACCUM;
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_ACCUM: begin
                    sum_reg <= sum_new;
                    if (!close_reg && end_reg) begin
                        // Closing angle from the last offset back to the first.
                        for (int k = 0; k < 3; k++) begin
                            a_reg[k] <= prev_reg[k];
                            b_reg[k] <= first_reg[k];
                        end
                        close_reg <= 1'b1;
                        state_reg <= ST_SCALE;
                    end else if (close_reg) begin
                        if (area_reg == 32'd0) begin
                            curv_reg    <= '0;
                            err_reg     <= 1'b1;
                            sum_reg     <= '0;
                            started_reg <= 1'b0;
                            state_reg   <= ST_OUT;
                        end else begin
                            neg_reg   <= num[41];
                            mag_reg   <= 64'(num_abs) << SH;
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_DIV;
                        end
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    rem_reg <= div_ge ? (rem_sh - {1'b0, area_reg}) : rem_sh;
                    quo_reg <= q_fin;
                    mag_reg <= mag_reg << 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        curv_reg    <= q_sat;
                        err_reg     <= 1'b0;
                        sum_reg     <= '0;
                        started_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A result never shows while a new request may be taken.
    `ADC_ASSERT_IMPLY(a_idle_no_result, aclk, aresetn, s_tready, !m_tvalid)
    // An area error always carries a zero curvature.
    `ADC_ASSERT_IMPLY(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 32'd0)
    // The angle sum stays within its saturation limit.
    `ADC_ASSERT_IMPLY(a_sum_bound, aclk, aresetn, 1'b1, sum_reg <= ANGLE_SUM_MAX)
    // The first neighbour of an open ring only stores its offset.
    `ADC_ASSERT_NEXT(a_open_ring, aclk, aresetn, accept && !started_reg && !s_tlast, s_tready)
    // Once a result is taken the block is ready again.
    `ADC_ASSERT_NEXT(a_result_release, aclk, aresetn, m_tvalid && m_tready, s_tready)

endmodule

>>> sim/tb_angle_deficit_curvature.sv
`timescale 1ns / 1ps
module tb_angle_deficit_curvature;

    // Run limit in clock cycles: long enough for the slowest legal run many times over.
    localparam int CYCLE_LIMIT = 4000000;
    localparam int FRAC_SHIFT  = 32 - adc_pkg::ANGLE_FRAC_BITS_DEF;
    localparam longint SUM_CEIL = (longint'(1) << 39) - 1;

    typedef struct packed {
        logic [31:0] curvature;
        logic        area_error;
    } curv_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;   // nbr x, nbr y, nbr z, ctr x, ctr y, ctr z, vertex area
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;   // curvature
    logic [0:0]   m_tuser;   // area_error

    angle_deficit_curvature dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor state for the ring in progress.
    longint ring_first[3];
    longint ring_prev[3];
    longint ring_angle_sum;
    bit     ring_open;

    curv_result_t curv_q[$];
    int errors;
    int requests_sent;
    int rings_sent;
    int results_seen;
    int zero_area_seen;
    int burst_left;
    int cycles;
    bit hold_request;

    // Clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Cycle counter and timeout.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, curv_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Normalise a vector so that its largest magnitude has exactly 15 bits.
    function automatic void normalise(input longint v[3], output longint o[3]);
        logic [63:0] m;
        logic [63:0] a;
        int len;
        m = 0;
        len = 0;
        for (int k = 0; k < 3; k++) begin
            a = (v[k] < 0) ? -v[k] : v[k];
            if (a > m) begin
                m = a;
            end
        end
        while ((m >> len) != 0) begin
            len++;
        end
        for (int k = 0; k < 3; k++) begin
            if (m == 0) begin
                o[k] = 0;
            end else if (len > adc_pkg::NORM_BITS) begin
                o[k] = v[k] >>> (len - adc_pkg::NORM_BITS);
            end else begin
                o[k] = v[k] <<< (adc_pkg::NORM_BITS - len);
            end
        end
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint cordic_step_angle(input int i);
        longint head[11];
        head = '{64'd3373259426, 1991351317, 1052175346, 534100634, 268086747,
                 134174062, 67103403, 33553749, 16777130, 8388597, 4194302};
        if (i < 11) begin
            return head[i];
        end
        return (longint'(1) << (32 - i)) - 1;
    endfunction

    // Vectoring CORDIC atan2 for y >= 0, in Q32 radians.
    function automatic longint cordic_atan2(input longint y, input longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(adc_pkg::HALF_PI_Q32);
        end
        for (int i = 0; i < 32; i++) begin
            if (y == 0) begin
                break;
            end
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + cordic_step_angle(i);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - cordic_step_angle(i);
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    // Q32 angle to the block's angle precision, rounding half up.
    function automatic longint q32_to_angle(input longint z);
        return (z + ((longint'(1) << FRAC_SHIFT) >>> 1)) >>> FRAC_SHIFT;
    endfunction

    function automatic longint angle_between(input longint a[3], input longint b[3]);
        longint p[3];
        longint q[3];
        longint c0;
        longint c1;
        longint c2;
        longint dot;
        logic [63:0] sq;
        normalise(a, p);
        normalise(b, q);
        c0 = p[1] * q[2] - p[2] * q[1];
        c1 = p[2] * q[0] - p[0] * q[2];
        c2 = p[0] * q[1] - p[1] * q[0];
        dot = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
        sq = 64'(c0 * c0) + 64'(c1 * c1) + 64'(c2 * c2);
        return q32_to_angle(cordic_atan2(longint'(int_sqrt(sq)), dot));
    endfunction

    function automatic void accumulate_angle(input longint ang);
        ring_angle_sum = ring_angle_sum + ang;
        if (ring_angle_sum > SUM_CEIL) begin
            ring_angle_sum = SUM_CEIL;
        end
    endfunction

    // Advance the ring by one neighbour; returns 1 with the curvature on the last one.
    function automatic bit predict_curvature(input logic [223:0] data, input logic last,
                                             output curv_result_t res);
        longint d[3];
        longint num;
        logic [63:0] mag;
        logic [63:0] quo;
        logic [31:0] area;
        for (int k = 0; k < 3; k++) begin
            d[k] = longint'($signed(data[32*k +: 32])) - longint'($signed(data[32*(k+3) +: 32]));
        end
        if (!ring_open) begin
            ring_first = d;
            ring_prev = d;
            ring_angle_sum = 0;
            ring_open = 1'b1;
        end else begin
            accumulate_angle(angle_between(ring_prev, d));
            ring_prev = d;
        end
        if (!last) begin
            return 1'b0;
        end
        accumulate_angle(angle_between(d, ring_first));
        area = data[223:192];
        if (area == 0) begin
            res.curvature = '0;
            res.area_error = 1'b1;
        end else begin
            num = q32_to_angle(longint'(adc_pkg::TWO_PI_Q32)) - ring_angle_sum;
            mag = 64'((num < 0) ? -num : num) << FRAC_SHIFT;
            quo = mag / {32'd0, area};
            if (num >= 0) begin
                res.curvature = (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
            end else begin
                res.curvature = (quo > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'h1_0000_0000 - quo);
            end
            res.area_error = 1'b0;
        end
        ring_angle_sum = 0;
        ring_open = 1'b0;
        return 1'b1;
    endfunction

    // Offer one neighbour request, with the sender's bursts and gaps, and wait for it.
    task automatic send_neighbour(input logic [31:0] nx, input logic [31:0] ny,
                                  input logic [31:0] nz, input logic [31:0] cx,
                                  input logic [31:0] cy, input logic [31:0] cz,
                                  input logic [31:0] area, input logic last);
        logic [223:0] data;
        curv_result_t res;
        int gap;
        data = {area, cz, cy, cx, nz, ny, nx};
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        if (predict_curvature(data, last, res)) begin
            curv_q.push_back(res);
            rings_sent++;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        requests_sent++;
        @(negedge aclk);
    endtask

    // Pause the sender until every outstanding curvature has been returned.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (curv_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Coordinate near a centre, anywhere, or at a range extreme.
    function automatic logic [31:0] pick_coord(input logic [31:0] ctr);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            return ctr + 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        end else if (sel < 90) begin
            return $urandom;
        end else if (sel < 95) begin
            return 32'h7FFF_FFFF;
        end
        return 32'h8000_0000;
    endfunction

    function automatic logic [31:0] pick_area();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
            return 32'd0;
        end else if (sel < 30) begin
            return $urandom_range(1, 16);
        end else if (sel < 34) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    // One ring with random content around a random centre.
    task automatic send_random_ring(input int len);
        logic [31:0] c[3];
        for (int k = 0; k < 3; k++) begin
            c[k] = $urandom;
        end
        for (int i = 0; i < len; i++) begin
            // Now and then the centre moves within a ring.
            if ($urandom_range(0, 49) == 0) begin
                c[$urandom_range(0, 2)] = $urandom;
            end
            // Occasionally the neighbour sits on the centre.
            if ($urandom_range(0, 39) == 0) begin
                send_neighbour(c[0], c[1], c[2], c[0], c[1], c[2], pick_area(), i == len - 1);
            end else begin
                send_neighbour(pick_coord(c[0]), pick_coord(c[1]), pick_coord(c[2]),
                               c[0], c[1], c[2], pick_area(), i == len - 1);
            end
        end
    endtask

    // Hand-picked rings: extremes, special cases and saturation both ways.
    task automatic test_directed();
        // Single neighbour: curvature is 2*pi over the area.
        send_neighbour(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b1);
        // Single neighbour with the smallest area saturates positive.
        send_neighbour(32'h0001_0000, 0, 0, 0, 0, 0, 32'd1, 1'b1);
        // Zero area raises the error flag but still closes the ring.
        send_neighbour(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b0);
        send_neighbour(0, 32'h0001_0000, 0, 0, 0, 0, 32'd0, 1'b1);
        // Flat square: four right angles, curvature zero.
        send_neighbour(32'h0001_0000, 0, 0, 0, 0, 0, 0, 1'b0);
        send_neighbour(0, 32'h0001_0000, 0, 0, 0, 0, 0, 1'b0);
        send_neighbour(32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 1'b0);
        send_neighbour(0, 32'hFFFF_0000, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1);
        // Opposite neighbours: sum exceeds 2*pi, small area saturates negative.
        send_neighbour(32'h0001_0000, 0, 0, 0, 0, 0, 0, 1'b0);
        send_neighbour(32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 1'b0);
        send_neighbour(32'h0001_0000, 0, 0, 0, 0, 0, 0, 1'b0);
        send_neighbour(32'hFFFF_0000, 0, 0, 0, 0, 0, 32'd1, 1'b1);
        // Widest offsets: coordinate extremes against the opposite centre extreme.
        send_neighbour(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
        send_neighbour(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 0, 1'b0);
        send_neighbour(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        // A neighbour on the centre contributes zero angles.
        send_neighbour(32'h0001_0000, 0, 0, 0, 0, 0, 0, 1'b0);
        send_neighbour(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
                       32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 0, 1'b0);
        send_neighbour(0, 32'h0001_0000, 0, 0, 0, 0, 32'h0000_8000, 1'b1);
        // Centre moves inside the ring.
        send_neighbour(32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 1'b0);
        send_neighbour(0, 32'h0002_0000, 32'h0000_0001, 0, 32'h0000_0100, 0, 0, 1'b0);
        send_neighbour(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0003_0000, 1'b1);
        wait_all_results();
    endtask

    // Ring far past the nominal maximum, every step turning by pi, so the sum saturates.
    task automatic test_long_ring();
        for (int i = 0; i < 340; i++) begin
            send_neighbour(i[0] ? 32'hFFFF_0000 : 32'h0001_0000, 0, 0, 0, 0, 0,
                           32'd1, i == 339);
        end
        // A ring just above the nominal maximum, without saturation.
        send_random_ring(70);
        wait_all_results();
    endtask

    // The receiver holds off for a long stretch while rings keep coming.
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int r = 0; r < 4; r++) begin
            send_random_ring($urandom_range(1, 3));
        end
        wait_all_results();
    endtask

    // Random rings, mostly short, a few long ones.
    task automatic test_random_rings();
        int sel;
        while (requests_sent < 1600) begin
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                send_random_ring($urandom_range(1, 6));
            end else if (sel < 97) begin
                send_random_ring($urandom_range(7, 20));
            end else begin
                send_random_ring($urandom_range(60, 70));
            end
            // Sometimes the sender waits for the block to empty.
            if ($urandom_range(0, 29) == 0) begin
                wait_all_results();
            end
        end
        wait_all_results();
    endtask

    // Receiver: switches among random stall patterns; long hold-off on request.
    initial begin : receiver
        int hold_left;
        int mode;
        hold_left = 0;
        mode = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 3000;
            end
            if (cycles % 64 == 0) begin
                mode = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (mode == 0) begin
                m_tready <= 1'b1;
            end else if (mode == 1) begin
                m_tready <= $urandom_range(0, 1);
            end else if (mode == 2) begin
                m_tready <= (cycles % 4 == 0);
            end else begin
                m_tready <= ($urandom_range(0, 9) == 0);
            end
        end
    end

    // Result checker: every returned curvature against the oldest prediction.
    always @(posedge aclk) begin
        curv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (curv_q.size() == 0) begin
                $error("Unexpected result: curvature %h area_error %b", m_tdata, m_tuser);
                errors++;
            end else begin
                want = curv_q.pop_front();
                if (want.area_error) begin
                    zero_area_seen++;
                end
                if (m_tdata !== want.curvature) begin
                    $error("curvature: expected %h, actual %h", want.curvature, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.area_error) begin
                    $error("area_error: expected %b, actual %b", want.area_error, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        errors = 0;
        requests_sent = 0;
        rings_sent = 0;
        results_seen = 0;
        zero_area_seen = 0;
        burst_left = 0;
        cycles = 0;
        hold_request = 1'b0;
        ring_open = 1'b0;
        ring_angle_sum = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_long_ring();
        test_backpressure();
        test_random_rings();

        s_tvalid <= 1'b0;
        repeat (300) @(negedge aclk);
        if (curv_q.size() != 0) begin
            $error("%0d results never arrived", curv_q.size());
            errors++;
        end
        $display("Covered %0d neighbour requests in %0d rings; %0d results, %0d with zero area.",
                 requests_sent, rings_sent, results_seen, zero_area_seen);
        $display("Included sum saturation, output saturation and long receiver hold-off.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/adc_pkg.sv
rtl/angle_deficit_curvature.sv
sim/tb_angle_deficit_curvature.sv
